>>> hw/rtl/ogr_pkg.sv
// Shared types and constants for the occupancy grid ray update block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package ogr_pkg;

  // Default map store geometry and counter width
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int COUNT_BITS_DEF = 16;

  // Coordinate fields in a command are wide enough for the largest map side
  localparam int COORD_BITS = 12;
  localparam int CFG_BITS   = 9;
  localparam int FIELD_BITS = 16;

  // Register indexes
  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  // Input function codes
  localparam logic [1:0] FN_RAY   = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_TRACED   = 3'd0;
  localparam logic [2:0] ST_SKIPPED  = 3'd1;
  localparam logic [2:0] ST_READ_OK  = 3'd2;
  localparam logic [2:0] ST_READ_OOB = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam logic [7:0] OCC_UNKNOWN = 8'd128;

  // Classified work handed from the front to the back
  typedef enum logic [2:0] {
    CMD_RAY   = 3'd0,
    CMD_SKIP  = 3'd1,
    CMD_READ  = 3'd2,
    CMD_RDOOB = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [COORD_BITS-1:0]   x0;
    logic [COORD_BITS-1:0]   y0;
    logic [COORD_BITS-1:0]   x1;
    logic [COORD_BITS-1:0]   y1;
    logic                    clamped;
  } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/ogr_ifs.sv
// Valid/ready channel interfaces for request and response items.
// Depends on ogr_pkg for the field widths.
`default_nettype none
interface ogr_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           func;
  logic signed [ogr_pkg::FIELD_BITS-1:0] robot_x;
  logic signed [ogr_pkg::FIELD_BITS-1:0] robot_y;
  logic signed [ogr_pkg::FIELD_BITS-1:0] end_x;
  logic signed [ogr_pkg::FIELD_BITS-1:0] end_y;
  logic signed [ogr_pkg::FIELD_BITS-1:0] cell_x;
  logic signed [ogr_pkg::FIELD_BITS-1:0] cell_y;

  modport source (output valid, func, robot_x, robot_y, end_x, end_y, cell_x, cell_y,
                  input ready);
  modport sink (input valid, func, robot_x, robot_y, end_x, end_y, cell_x, cell_y,
                output ready);
endinterface

interface ogr_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] occupancy;
  logic [8:0] cells_updated;
  logic       start_clamped;

  modport source (output valid, status, occupancy, cells_updated, start_clamped,
                  input ready);
  modport sink (input valid, status, occupancy, cells_updated, start_clamped,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/occupancy_grid_ray_update.sv
// Occupancy grid ray update. A ray reads and then writes back each cell walked,
// bounded by the single counter-memory port (read, then write back).
// A cell read is a memory read plus, once the cell holds two or more counts, an 8-step serial divider.
// A map clear writes all 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) counter cells.
// After reset the same sweep clears the memory, during which no request item
// is accepted; configuration writes are taken.
`default_nettype none
module occupancy_grid_ray_update #(
  parameter int MAX_WIDTH  = ogr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ogr_pkg::MAX_HEIGHT_DEF,
  parameter int COUNT_BITS = ogr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [ogr_pkg::CFG_BITS-1:0] cfg_data,
  ogr_req_if.sink                           req,
  ogr_rsp_if.source                         rsp
);
  logic [ogr_pkg::CFG_BITS-1:0] map_width, map_height;
  ogr_pkg::cmd_t                push_cmd, head_cmd;
  logic                         push, pop, full, empty, init_busy;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= ogr_pkg::CFG_BITS'(256);
      map_height <= ogr_pkg::CFG_BITS'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ogr_pkg::CFG_MAP_WIDTH:  map_width  <= cfg_data;
        ogr_pkg::CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ogr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .map_width (map_width),
    .map_height(map_height),
    .enable    (!init_busy),
    .full      (full),
    .req       (req),
    .push      (push),
    .cmd       (push_cmd)
  );

  ogr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_cmd(push_cmd),
    .pop   (pop),
    .rd_cmd(head_cmd),
    .full  (full),
    .empty (empty)
  );

  ogr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .cmd      (head_cmd),
    .pop      (pop),
    .init_busy(init_busy),
    .rsp      (rsp)
  );

  // Occupancy is only nonzero on read results
  a_occ_read_only: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.occupancy != 8'd0) |->
      (rsp.status == ogr_pkg::ST_READ_OK) || (rsp.status == ogr_pkg::ST_READ_OOB))
    else $error("occupancy on a non-read result");

  // Out-of-bounds reads report unknown
  a_oob_unknown: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ogr_pkg::ST_READ_OOB) |->
      rsp.occupancy == ogr_pkg::OCC_UNKNOWN)
    else $error("out-of-bounds read not unknown");

  // Cells are counted only for traced rays, and a traced ray touches one at least
  a_cells_traced: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.cells_updated != 9'd0) == (rsp.status == ogr_pkg::ST_TRACED)))
    else $error("cell count does not match status");

  // No request item is taken during the power-up clearing sweep
  a_no_accept_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !push)
    else $error("item accepted while clearing");
endmodule
`default_nettype wire

>>> hw/rtl/ogr_front.sv
// Front end: accepts request items, clamps and bounds-checks coordinates,
// and pushes one classified command per item. Depends on ogr_pkg, ogr_ifs.
`default_nettype none
module ogr_front #(
  parameter int MAX_WIDTH  = ogr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ogr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic [ogr_pkg::CFG_BITS-1:0] map_width,
  input  wire logic [ogr_pkg::CFG_BITS-1:0] map_height,
  input  wire logic                         enable,
  input  wire logic                         full,
  ogr_req_if.sink                           req,
  output      logic                         push,
  output      ogr_pkg::cmd_t                cmd
);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int CB = ogr_pkg::COORD_BITS;

  logic [WB-1:0]      w_used;
  logic [HB-1:0]      h_used;
  logic signed [17:0] w_s, h_s;
  logic signed [17:0] x0, y0, x1, y1, rx, ry, cx, cy;
  logic               end_in, cell_in;

  // Saturate the size registers into the store
  always_comb begin
    if (map_width == '0) w_used = WB'(1);
    else if (32'(map_width) > 32'(MAX_WIDTH)) w_used = WB'(MAX_WIDTH);
    else w_used = WB'(map_width);
    if (map_height == '0) h_used = HB'(1);
    else if (32'(map_height) > 32'(MAX_HEIGHT)) h_used = HB'(MAX_HEIGHT);
    else h_used = HB'(map_height);
  end

  assign w_s = signed'(18'(w_used));
  assign h_s = signed'(18'(h_used));
  assign x0  = 18'(req.robot_x);
  assign y0  = 18'(req.robot_y);
  assign x1  = 18'(req.end_x);
  assign y1  = 18'(req.end_y);
  assign rx  = 18'(req.cell_x);
  assign ry  = 18'(req.cell_y);

  // Clamp the ray start into the map
  always_comb begin
    if (x0 < 18'sd0) cx = 18'sd0;
    else if (x0 > w_s - 18'sd1) cx = w_s - 18'sd1;
    else cx = x0;
    if (y0 < 18'sd0) cy = 18'sd0;
    else if (y0 > h_s - 18'sd1) cy = h_s - 18'sd1;
    else cy = y0;
  end

  assign end_in  = (x1 >= 18'sd0) && (x1 < w_s) && (y1 >= 18'sd0) && (y1 < h_s);
  assign cell_in = (rx >= 18'sd0) && (rx < w_s) && (ry >= 18'sd0) && (ry < h_s);

  // Classify the item
  always_comb begin
    cmd.x0      = cx[CB-1:0];
    cmd.y0      = cy[CB-1:0];
    cmd.x1      = x1[CB-1:0];
    cmd.y1      = y1[CB-1:0];
    cmd.clamped = 1'b0;
    unique case (req.func)
      ogr_pkg::FN_RAY: begin
        cmd.kind    = end_in ? ogr_pkg::CMD_RAY : ogr_pkg::CMD_SKIP;
        cmd.clamped = (cx != x0) || (cy != y0);
      end
      ogr_pkg::FN_READ: begin
        cmd.kind = cell_in ? ogr_pkg::CMD_READ : ogr_pkg::CMD_RDOOB;
        cmd.x1   = rx[CB-1:0];
        cmd.y1   = ry[CB-1:0];
      end
      ogr_pkg::FN_CLEAR: cmd.kind = ogr_pkg::CMD_CLEAR;
      default:           cmd.kind = ogr_pkg::CMD_SKIP;
    endcase
  end

  assign req.ready = enable && !full;
  assign push      = req.valid && req.ready;
endmodule
`default_nettype wire

>>> hw/rtl/ogr_fifo.sv
// Two-entry command queue between the front and back ends.
// Depends on ogr_pkg for the command type.
`default_nettype none
module ogr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ogr_pkg::cmd_t wr_cmd,
  input  wire logic          pop,
  output      ogr_pkg::cmd_t rd_cmd,
  output      logic          full,
  output      logic          empty
);
  ogr_pkg::cmd_t slots [2];
  logic          head, tail;
  logic [1:0]    count;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) slots[tail] <= wr_cmd;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) tail <= ~tail;
      if (pop) head <= ~head;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  assign rd_cmd = slots[head];
  assign full   = count == 2'd2;
  assign empty  = count == 2'd0;
endmodule
`default_nettype wire

>>> hw/rtl/ogr_back.sv
// Back end: owns the hit/miss counter memory, walks rays, computes cell
// occupancy with a serial divider, clears the map. Depends on ogr_pkg, ogr_ifs.
`default_nettype none
module ogr_back #(
  parameter int MAX_WIDTH  = ogr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ogr_pkg::MAX_HEIGHT_DEF,
  parameter int COUNT_BITS = ogr_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  wire ogr_pkg::cmd_t cmd,
  output      logic          pop,
  output      logic          init_busy,
  ogr_rsp_if.source          rsp
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int EW = ((XW > YW) ? XW : YW) + 3;
  localparam int TW = COUNT_BITS + 1;
  localparam int NW = COUNT_BITS + 13;
  localparam int MW = 2 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_RAY_RD = 8'b0000_0100,
    S_RAY_WR = 8'b0000_1000,
    S_OCC_RD = 8'b0001_0000,
    S_OCC_SET = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  logic   init;

  // Counter memory: {hits, misses} per cell
  logic [MW-1:0] mem [2**AW];
  logic [MW-1:0] rdata;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] caddr;

  // Ray walk registers
  logic [XW-1:0]        x, x1;
  logic [YW-1:0]        y, y1;
  logic signed [EW-1:0] dx, dy, err;
  logic                 sx, sy;
  logic [8:0]           n;

  // Divider registers
  logic [NW-1:0] rem, dsh;
  logic [7:0]    q;
  logic [2:0]    step;

  // Result registers
  logic [2:0] res_status;
  logic [7:0] res_occ;
  logic [8:0] res_cells;
  logic       res_clamped;

  logic                 at_end;
  logic signed [EW:0]   e2;
  logic signed [EW-1:0] err_next;
  logic [XW-1:0]        x_next;
  logic [YW-1:0]        y_next;
  logic [COUNT_BITS-1:0] hits, misses;
  logic [COUNT_BITS:0]   hit_sum;
  logic [TW-1:0]         total;
  logic [NW-1:0]         hh, tt, num_next, den_next;
  logic [8:0]            n_next;

  assign hits    = rdata[MW-1:COUNT_BITS];
  assign misses  = rdata[COUNT_BITS-1:0];
  assign hit_sum = {1'b0, hits} + (COUNT_BITS + 1)'(3);
  assign at_end  = (x == x1) && (y == y1);
  assign n_next  = (n == 9'h1FF) ? n : n + 9'd1;

  // Bresenham step from the current error
  always_comb begin
    e2       = (EW + 1)'(err) <<< 1;
    err_next = err;
    x_next   = x;
    y_next   = y;
    if (e2 > -((EW + 1)'(dy))) begin
      err_next = err_next - dy;
      x_next   = sx ? x + XW'(1) : x - XW'(1);
    end
    if (e2 < (EW + 1)'(dx)) begin
      err_next = err_next + dx;
      y_next   = sy ? y + YW'(1) : y - YW'(1);
    end
  end

  // Pick the curve segment and its fraction
  always_comb begin
    total = TW'(hits) + TW'(misses);
    hh    = NW'(hits);
    tt    = NW'(total);
    if (((hh << 2) + hh) > ((tt << 1) + tt)) begin
      num_next = (tt << 10) + (tt << 8) + (tt << 7) + (tt << 6) + (hh << 10) - (hh << 6);
      den_next = (tt << 3) + (tt << 1);
    end else if (((hh << 2) + hh) < (tt << 1)) begin
      num_next = (tt << 7) + (hh << 10) - (hh << 6);
      den_next = (tt << 3) + (tt << 1);
    end else begin
      num_next = (hh << 9) + (hh << 8) - (tt << 8);
      den_next = tt;
    end
  end

  // Memory port controls
  always_comb begin
    mem_re    = (state == S_RAY_RD) || (state == S_OCC_RD);
    mem_we    = 1'b0;
    mem_waddr = {y, x};
    mem_wdata = rdata;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = caddr;
      mem_wdata = '0;
    end else if (state == S_RAY_WR) begin
      mem_we = 1'b1;
      if (at_end) mem_wdata = {hit_sum[COUNT_BITS] ? COUNT_MAX : hit_sum[COUNT_BITS-1:0],
                               misses};
      else mem_wdata = {hits, (misses == COUNT_MAX) ? misses : misses + COUNT_BITS'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[{y, x}];
  end

  assign pop       = (state == S_IDLE) && !empty;
  assign init_busy = init;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init      <= 1'b1;
      caddr     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE)) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          caddr <= caddr + AW'(1);
          if (caddr == '1) begin
            init <= 1'b0;
            if (init) begin
              state <= S_IDLE;
            end else begin
              res_status <= ogr_pkg::ST_CLEARED;
              state      <= S_DONE;
            end
          end
        end
        S_IDLE: begin
          if (!empty) begin
            res_occ     <= (cmd.kind == ogr_pkg::CMD_RDOOB) ? ogr_pkg::OCC_UNKNOWN : 8'd0;
            res_cells   <= 9'd0;
            res_clamped <= cmd.clamped;
            x  <= (cmd.kind == ogr_pkg::CMD_READ) ? cmd.x1[XW-1:0] : cmd.x0[XW-1:0];
            y  <= (cmd.kind == ogr_pkg::CMD_READ) ? cmd.y1[YW-1:0] : cmd.y0[YW-1:0];
            x1 <= cmd.x1[XW-1:0];
            y1 <= cmd.y1[YW-1:0];
            unique case (cmd.kind)
              ogr_pkg::CMD_RAY: begin
                dx  <= (cmd.x1 > cmd.x0) ? EW'(cmd.x1[XW-1:0] - cmd.x0[XW-1:0])
                                         : EW'(cmd.x0[XW-1:0] - cmd.x1[XW-1:0]);
                dy  <= (cmd.y1 > cmd.y0) ? EW'(cmd.y1[YW-1:0] - cmd.y0[YW-1:0])
                                         : EW'(cmd.y0[YW-1:0] - cmd.y1[YW-1:0]);
                err <= ((cmd.x1 > cmd.x0) ? EW'(cmd.x1[XW-1:0] - cmd.x0[XW-1:0])
                                          : EW'(cmd.x0[XW-1:0] - cmd.x1[XW-1:0]))
                     - ((cmd.y1 > cmd.y0) ? EW'(cmd.y1[YW-1:0] - cmd.y0[YW-1:0])
                                          : EW'(cmd.y0[YW-1:0] - cmd.y1[YW-1:0]));
                sx  <= cmd.x0 < cmd.x1;
                sy  <= cmd.y0 < cmd.y1;
                n   <= 9'd0;
                state <= S_RAY_RD;
              end
              ogr_pkg::CMD_READ: begin
                state <= S_OCC_RD;
              end
              ogr_pkg::CMD_RDOOB: begin
                res_status <= ogr_pkg::ST_READ_OOB;
                state      <= S_DONE;
              end
              ogr_pkg::CMD_CLEAR: begin
                caddr <= '0;
                state <= S_CLEAR;
              end
              default: begin
                res_status  <= ogr_pkg::ST_SKIPPED;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_RAY_RD: state <= S_RAY_WR;
        S_RAY_WR: begin
          n <= n_next;
          if (at_end) begin
            res_status <= ogr_pkg::ST_TRACED;
            res_cells  <= n_next;
            state      <= S_DONE;
          end else begin
            x     <= x_next;
            y     <= y_next;
            err   <= err_next;
            state <= S_RAY_RD;
          end
        end
        S_OCC_RD: state <= S_OCC_SET;
        S_OCC_SET: begin
          res_status <= ogr_pkg::ST_READ_OK;
          if (total < TW'(2)) begin
            res_occ <= ogr_pkg::OCC_UNKNOWN;
            state   <= S_DONE;
          end else begin
            rem   <= num_next;
            dsh   <= den_next << 7;
            q     <= 8'd0;
            step  <= 3'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle, most significant first
          if (rem >= dsh) rem <= rem - dsh;
          q    <= {q[6:0], rem >= dsh};
          dsh  <= dsh >> 1;
          step <= step + 3'd1;
          if (step == 3'd7) begin
            res_occ <= {q[6:0], rem >= dsh};
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp.valid || rsp.ready)) begin
      rsp.status        <= res_status;
      rsp.occupancy     <= res_occ;
      rsp.cells_updated <= res_cells;
      rsp.start_clamped <= res_clamped;
    end
  end
endmodule
`default_nettype wire

>>> tb/occupancy_grid_ray_update_tb.sv
// Testbench for the occupancy grid ray update block: directed and random rays,
// reads and clears, checked against a predictor kept in a small scoreboard class.
// Depends on ogr_pkg, ogr_ifs and occupancy_grid_ray_update.
`timescale 1ns / 100ps

module occupancy_grid_ray_update_tb;

  localparam int GRID_W      = ogr_pkg::MAX_WIDTH_DEF;
  localparam int GRID_H      = ogr_pkg::MAX_HEIGHT_DEF;
  localparam int COUNT_LIMIT = (1 << ogr_pkg::COUNT_BITS_DEF) - 1;
  localparam int IDLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS = 100;

  typedef logic signed [ogr_pkg::FIELD_BITS-1:0] coord_t;

  typedef struct {
    logic [1:0] func;
    coord_t     rx, ry, ex, ey, qx, qy;
  } grid_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] occupancy;
    logic [8:0] cells;
    logic       clamped;
  } grid_rsp_t;

  // Map model: counters, sizes in use and the queue of expected results
  class grid_scoreboard;
    int unsigned hit_cnt[int];
    int unsigned miss_cnt[int];
    int          width_reg = 256;
    int          height_reg = 256;
    grid_rsp_t   expected_q[$];
    int          mismatches = 0;

    function int used_size(int reg_val, int maxv);
      int s;
      s = reg_val & 'h1FF;
      if (s < 1) s = 1;
      if (s > maxv) s = maxv;
      return s;
    endfunction

    function int map_w();
      return used_size(width_reg, GRID_W);
    endfunction

    function int map_h();
      return used_size(height_reg, GRID_H);
    endfunction

    function void bump(ref int unsigned cnt[int], input int k, input int inc);
      int unsigned v;
      v = cnt.exists(k) ? cnt[k] : 0;
      v = v + inc;
      cnt[k] = (v > COUNT_LIMIT) ? COUNT_LIMIT : v;
    endfunction

    function int unsigned occupancy_of(longint unsigned h, longint unsigned m);
      longint unsigned t, v;
      t = h + m;
      if (t < 2) return 128;
      if (5 * h > 3 * t) v = (1472 * t + 960 * h) / (10 * t);
      else if (5 * h < 2 * t) v = (128 * t + 960 * h) / (10 * t);
      else v = (768 * h - 256 * t) / t;
      return (v > 255) ? 255 : int'(v);
    endfunction

    // Walk a ray from the clamped start to the end cell
    function grid_rsp_t trace_ray(grid_req_t it);
      grid_rsp_t r;
      int w, h, cx, cy, x1, y1, dx, dy, sx, sy, err, e2, x, y, n;
      w = map_w();
      h = map_h();
      r = '{ogr_pkg::ST_SKIPPED, 8'd0, 9'd0, 1'b0};
      cx = (it.rx < 0) ? 0 : ((it.rx > w - 1) ? w - 1 : int'(it.rx));
      cy = (it.ry < 0) ? 0 : ((it.ry > h - 1) ? h - 1 : int'(it.ry));
      r.clamped = (cx != it.rx) || (cy != it.ry);
      x1 = it.ex;
      y1 = it.ey;
      if (x1 < 0 || x1 >= w || y1 < 0 || y1 >= h) return r;
      dx = (x1 > cx) ? x1 - cx : cx - x1;
      dy = (y1 > cy) ? y1 - cy : cy - y1;
      sx = (cx < x1) ? 1 : -1;
      sy = (cy < y1) ? 1 : -1;
      err = dx - dy;
      x = cx;
      y = cy;
      n = 0;
      forever begin
        n++;
        if (x == x1 && y == y1) begin
          bump(hit_cnt, y * GRID_W + x, 3);
          break;
        end
        bump(miss_cnt, y * GRID_W + x, 1);
        e2 = 2 * err;
        if (e2 > -dy) begin err -= dy; x += sx; end
        if (e2 < dx) begin err += dx; y += sy; end
      end
      r.status = ogr_pkg::ST_TRACED;
      r.cells = (n > 511) ? 9'd511 : n[8:0];
      return r;
    endfunction

    function void note_request(grid_req_t it);
      grid_rsp_t r;
      int k;
      r = '{ogr_pkg::ST_SKIPPED, 8'd0, 9'd0, 1'b0};
      case (it.func)
        ogr_pkg::FN_RAY: begin
          r = trace_ray(it);
        end
        ogr_pkg::FN_READ: begin
          if (it.qx >= 0 && it.qx < map_w() && it.qy >= 0 && it.qy < map_h()) begin
            k = it.qy * GRID_W + it.qx;
            r.status = ogr_pkg::ST_READ_OK;
            r.occupancy = occupancy_of(hit_cnt.exists(k) ? hit_cnt[k] : 0,
                                       miss_cnt.exists(k) ? miss_cnt[k] : 0);
          end else begin
            r.status = ogr_pkg::ST_READ_OOB;
            r.occupancy = ogr_pkg::OCC_UNKNOWN;
          end
        end
        ogr_pkg::FN_CLEAR: begin
          hit_cnt.delete();
          miss_cnt.delete();
          r.status = ogr_pkg::ST_CLEARED;
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(grid_rsp_t got);
      grid_rsp_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d occ %0d cells %0d clamped %0d",
                   got.status, got.occupancy, got.cells, got.clamped);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got != exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st %0d occ %0d cells %0d cl %0d,",
                    " got st %0d occ %0d cells %0d cl %0d"},
                   exp_r.status, exp_r.occupancy, exp_r.cells, exp_r.clamped,
                   got.status, got.occupancy, got.cells, got.clamped);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = ogr_pkg::CFG_MAP_WIDTH;
  logic [ogr_pkg::CFG_BITS-1:0] cfg_data = '0;

  ogr_req_if req ();
  ogr_rsp_if rsp ();

  grid_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  occupancy_grid_ray_update i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.func = ogr_pkg::FN_READ;
    req.robot_x = '0;
    req.robot_y = '0;
    req.end_x = '0;
    req.end_y = '0;
    req.cell_x = '0;
    req.cell_y = '0;
    rsp.ready = 1'b0;
  end

  // Stall the result side on one of four patterns, redrawn at random times
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= $urandom_range(0, 1);
      2: rsp.ready <= ($urandom_range(0, 3) == 0);
      default: rsp.ready <= ($urandom_range(0, 15) != 0);
    endcase
    if (rsp.valid && rsp.ready)
      sb.check_result('{rsp.status, rsp.occupancy, rsp.cells_updated, rsp.start_clamped});
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("occupancy_grid_ray_update_tb failed");
      $finish;
    end
  end

  // Offer one item in bursts with random gaps, and hold it until accepted
  task automatic send_item(grid_req_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    req.valid <= 1'b1;
    req.func <= it.func;
    req.robot_x <= it.rx;
    req.robot_y <= it.ry;
    req.end_x <= it.ex;
    req.end_y <= it.ey;
    req.cell_x <= it.qx;
    req.cell_y <= it.qy;
    do @(posedge clk); while (!req.ready);
    sb.note_request(it);
    burst_left--;
  endtask

  // Wait until every expected result has come back
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(logic idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ogr_pkg::CFG_MAP_WIDTH) sb.width_reg = value & 'h1FF;
    else sb.height_reg = value & 'h1FF;
  endtask

  function automatic grid_req_t mk(logic [1:0] f, int rx, int ry, int ex, int ey,
                                   int qx, int qy);
    grid_req_t it;
    it.func = f;
    it.rx = rx;
    it.ry = ry;
    it.ex = ex;
    it.ey = ey;
    it.qx = qx;
    it.qy = qy;
    return it;
  endfunction

  // Mostly in-map coordinates, some just outside and some anywhere
  function automatic int rand_coord(int limit);
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom()));
      1: return -$urandom_range(1, 3);
      2: return limit + $urandom_range(0, 2);
      default: return $urandom_range(0, limit - 1);
    endcase
  endfunction

  function automatic grid_req_t rand_item();
    int w, h, sel, cx, cy;
    logic [1:0] f;
    w = sb.map_w();
    h = sb.map_h();
    sel = $urandom_range(0, 199);
    if (sel < 2) f = ogr_pkg::FN_CLEAR;
    else if (sel < 6) f = 2'd3;
    else if (sel < 116) f = ogr_pkg::FN_RAY;
    else f = ogr_pkg::FN_READ;
    // Draw read coordinates the same way as ray coordinates
    cx = rand_coord(w);
    cy = rand_coord(h);
    return mk(f, rand_coord(w), rand_coord(h), rand_coord(w), rand_coord(h), cx, cy);
  endfunction

  initial begin
    int phase_w[6] = '{256, 1, 0, 7, 511, 40};
    int phase_h[6] = '{256, 1, 300, 5, 511, 3};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset sizes, unknown cells, clamping, skips, long ray, clear
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, 0, 0));
    send_item(mk(ogr_pkg::FN_RAY, 0, 0, 255, 255, 0, 0));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, 255, 255));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, 0, 0));
    send_item(mk(ogr_pkg::FN_RAY, -32768, -5, 3, 3, 0, 0));
    send_item(mk(ogr_pkg::FN_RAY, 32767, 300, 3, 3, 0, 0));
    send_item(mk(ogr_pkg::FN_RAY, 10, 10, 3, 3, 0, 0));
    send_item(mk(ogr_pkg::FN_RAY, 3, 3, 3, 3, 0, 0));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, 3, 3));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, 5, 5));
    send_item(mk(ogr_pkg::FN_RAY, -1, -1, 256, 0, 0, 0));
    send_item(mk(ogr_pkg::FN_RAY, 5, 5, -1, 32767, 0, 0));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, -1, 0));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, 0, 256));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, -32768, 32767));
    send_item(mk(2'd3, -1, -1, -1, -1, -1, -1));
    send_item(mk(ogr_pkg::FN_RAY, 255, 0, 0, 255, 0, 0));
    send_item(mk(ogr_pkg::FN_RAY, 0, 200, 250, 7, 0, 0));
    send_item(mk(ogr_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(mk(ogr_pkg::FN_READ, 0, 0, 0, 0, 3, 3));
    drain();

    // Random phases over several map sizes, extremes among them
    for (int p = 0; p < 6; p++) begin
      write_size(ogr_pkg::CFG_MAP_WIDTH, phase_w[p]);
      write_size(ogr_pkg::CFG_MAP_HEIGHT, phase_h[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(rand_item());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("occupancy_grid_ray_update_tb passed");
    else
      $display("occupancy_grid_ray_update_tb failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ogr_pkg.sv
hw/rtl/ogr_ifs.sv
hw/rtl/ogr_front.sv
hw/rtl/ogr_fifo.sv
hw/rtl/ogr_back.sv
hw/rtl/occupancy_grid_ray_update.sv
tb/occupancy_grid_ray_update_tb.sv
